FILE: rtl/core/khist_pkg.sv
package khist_pkg;

  localparam int SENSOR_ID_W = 16;
  localparam int CATEGORY_W  = 3;
  localparam int SLOT_W      = 8;
  localparam int LEVEL_W     = 3;
  localparam int TALLY_W     = 32;
  localparam int USED_W      = 9;

  // Input tdata layout.
  localparam int IN_ID_LSB   = 0;
  localparam int IN_CAT_LSB  = IN_ID_LSB + SENSOR_ID_W;
  localparam int IN_SLOT_LSB = IN_CAT_LSB + CATEGORY_W;
  localparam int IN_FIELDS_W = IN_SLOT_LSB + SLOT_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata layout.
  localparam int OUT_ID_LSB    = 0;
  localparam int OUT_LEVEL_LSB = OUT_ID_LSB + SENSOR_ID_W;
  localparam int OUT_TALLY_LSB = OUT_LEVEL_LSB + LEVEL_W;
  localparam int OUT_USED_LSB  = OUT_TALLY_LSB + TALLY_W;
  localparam int OUT_OVF_LSB   = OUT_USED_LSB + USED_W;
  localparam int OUT_FIELDS_W  = OUT_OVF_LSB + 1;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ALLOC,
    ST_CLEAR,
    ST_INC_RD,
    ST_INC_WR,
    ST_RB_CHK,
    ST_RB_RD,
    ST_RB_LOAD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic srch;
    logic alloc;
    logic clr;
    logic set_ovf;
    logic inc_rd;
    logic inc_wr;
    logic rb_rd;
    logic rb_load;
    logic rb_empty;
    logic rb_next;
  } cmd_t;

  typedef struct packed {
    logic in_read;
    logic hit;
    logic miss;
    logic full;
    logic cat_ok;
    logic clr_done;
    logic slot_ok;
    logic out_taken;
    logic out_last;
  } status_t;

endpackage

FILE: rtl/core/khist_dp.sv
module khist_dp
  import khist_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int NUM_LEVELS    = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  in_mode_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_entry_valid_o,
  output logic                  out_last_o
);

  localparam int UW  = $clog2(TABLE_ENTRIES + 1);
  localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int KW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CD  = TABLE_ENTRIES * NUM_LEVELS;
  localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
  localparam int CW  = (UW > SLOT_W) ? UW : SLOT_W;

  logic [SENSOR_ID_W-1:0] ids_mem [TABLE_ENTRIES];
  logic [TALLY_W-1:0]     cnt_mem [CD];

  logic [SENSOR_ID_W-1:0] id_q;
  logic [CATEGORY_W-1:0]  cat_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [UW-1:0]          used_q;
  logic                   ovf_q;
  logic [UW-1:0]          i_q;
  logic                   cmp_v_q;
  logic [IW-1:0]          cmp_idx_q;
  logic [IW-1:0]          idx_q;
  logic [KW-1:0]          k_q;
  logic [SENSOR_ID_W-1:0] id_rd_q;
  logic [TALLY_W-1:0]     cnt_rd_q;

  logic                   out_valid_q;
  logic                   out_entry_valid_q;
  logic [SENSOR_ID_W-1:0] out_id_q;
  logic [LEVEL_W-1:0]     out_level_q;
  logic [TALLY_W-1:0]     out_tally_q;
  logic [USED_W-1:0]      out_used_q;
  logic                   out_ovf_q;
  logic                   out_last_q;

  logic                   hit;
  logic                   issue;
  logic                   id_re;
  logic [IW-1:0]          id_raddr;
  logic [KW-1:0]          k_sel;
  logic [CAW-1:0]         cnt_addr;
  logic                   cnt_re;
  logic                   cnt_we;
  logic [TALLY_W-1:0]     cnt_sat;
  logic [TALLY_W-1:0]     cnt_wdata;
  logic                   k_last;

  assign hit      = cmp_v_q && (id_rd_q == id_q);
  assign issue    = cmd_i.srch && !hit && (i_q < used_q);
  assign id_re    = issue | cmd_i.rb_rd;
  assign id_raddr = issue ? i_q[IW-1:0] : idx_q;
  assign k_sel    = (cmd_i.inc_rd | cmd_i.inc_wr) ? KW'(cat_q) : k_q;
  assign cnt_addr = CAW'(idx_q) * CAW'(NUM_LEVELS) + CAW'(k_sel);
  assign cnt_re   = cmd_i.inc_rd | cmd_i.rb_rd;
  assign cnt_we   = cmd_i.clr | cmd_i.inc_wr;
  assign cnt_sat  = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + TALLY_W'(1);
  assign cnt_wdata = cmd_i.clr ? '0 : cnt_sat;
  assign k_last   = (k_q == KW'(NUM_LEVELS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      ids_mem[used_q[IW-1:0]] <= id_q;
    end
    if (id_re) begin
      id_rd_q <= ids_mem[id_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_addr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q   <= in_data_i[IN_ID_LSB +: SENSOR_ID_W];
      cat_q  <= in_data_i[IN_CAT_LSB +: CATEGORY_W];
      slot_q <= in_data_i[IN_SLOT_LSB +: SLOT_W];
    end
    if (issue) begin
      cmp_idx_q <= i_q[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      cmp_v_q <= 1'b0;
      idx_q   <= '0;
      k_q     <= '0;
    end else begin
      if (cmd_i.alloc) begin
        used_q <= used_q + UW'(1);
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.load) begin
        i_q     <= '0;
        cmp_v_q <= 1'b0;
      end else if (cmd_i.srch) begin
        cmp_v_q <= issue;
        if (issue) begin
          i_q <= i_q + UW'(1);
        end
      end
      if (cmd_i.load) begin
        idx_q <= IW'(in_data_i[IN_SLOT_LSB +: SLOT_W]);
      end else if (cmd_i.srch && hit) begin
        idx_q <= cmp_idx_q;
      end else if (cmd_i.alloc) begin
        idx_q <= used_q[IW-1:0];
      end
      if (cmd_i.load || cmd_i.alloc) begin
        k_q <= '0;
      end else if (cmd_i.clr || cmd_i.rb_next) begin
        k_q <= k_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rb_load || cmd_i.rb_empty) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rb_load) begin
      out_entry_valid_q <= 1'b1;
      out_id_q          <= id_rd_q;
      out_level_q       <= LEVEL_W'(k_q);
      out_tally_q       <= cnt_rd_q;
      out_used_q        <= USED_W'(used_q);
      out_ovf_q         <= ovf_q;
      out_last_q        <= k_last;
    end else if (cmd_i.rb_empty) begin
      out_entry_valid_q <= 1'b0;
      out_id_q          <= '0;
      out_level_q       <= '0;
      out_tally_q       <= '0;
      out_used_q        <= USED_W'(used_q);
      out_ovf_q         <= ovf_q;
      out_last_q        <= 1'b1;
    end
  end

  always_comb begin
    status_o           = '0;
    status_o.in_read   = in_mode_i;
    status_o.hit       = hit;
    status_o.miss      = !cmp_v_q && (i_q >= used_q);
    status_o.full      = (used_q >= UW'(TABLE_ENTRIES));
    status_o.cat_ok    = ({2'b00, cat_q} < 5'(NUM_LEVELS));
    status_o.clr_done  = k_last;
    status_o.slot_ok   = (CW'(slot_q) < CW'(used_q));
    status_o.out_taken = out_valid_q & out_ready_i;
    status_o.out_last  = out_last_q;
  end

  always_comb begin
    out_data_o = '0;
    out_data_o[OUT_ID_LSB +: SENSOR_ID_W] = out_id_q;
    out_data_o[OUT_LEVEL_LSB +: LEVEL_W]  = out_level_q;
    out_data_o[OUT_TALLY_LSB +: TALLY_W]  = out_tally_q;
    out_data_o[OUT_USED_LSB +: USED_W]    = out_used_q;
    out_data_o[OUT_OVF_LSB]               = out_ovf_q;
  end

  assign out_valid_o       = out_valid_q;
  assign out_entry_valid_o = out_entry_valid_q;
  assign out_last_o        = out_last_q;

endmodule

FILE: rtl/core/khist_ctrl.sv
module khist_ctrl
  import khist_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.in_read ? ST_RB_CHK : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status_i.hit) begin
          state_d = status_i.cat_ok ? ST_INC_RD : ST_IDLE;
        end else if (status_i.miss) begin
          state_d = status_i.full ? ST_IDLE : ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        state_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (status_i.clr_done) begin
          state_d = status_i.cat_ok ? ST_INC_RD : ST_IDLE;
        end
      end
      ST_INC_RD: begin
        state_d = ST_INC_WR;
      end
      ST_INC_WR: begin
        state_d = ST_IDLE;
      end
      ST_RB_CHK: begin
        state_d = status_i.slot_ok ? ST_RB_RD : ST_OUT;
      end
      ST_RB_RD: begin
        state_d = ST_RB_LOAD;
      end
      ST_RB_LOAD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_taken) begin
          state_d = status_i.out_last ? ST_IDLE : ST_RB_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SEARCH: begin
        cmd_o.srch    = 1'b1;
        cmd_o.set_ovf = !status_i.hit && status_i.miss && status_i.full;
      end
      ST_ALLOC: begin
        cmd_o.alloc = 1'b1;
      end
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
      end
      ST_INC_RD: begin
        cmd_o.inc_rd = 1'b1;
      end
      ST_INC_WR: begin
        cmd_o.inc_wr = 1'b1;
      end
      ST_RB_CHK: begin
        cmd_o.rb_empty = !status_i.slot_ok;
      end
      ST_RB_RD: begin
        cmd_o.rb_rd = 1'b1;
      end
      ST_RB_LOAD: begin
        cmd_o.rb_load = 1'b1;
      end
      ST_OUT: begin
        cmd_o.rb_next = status_i.out_taken && !status_i.out_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/keyed_category_histogram.sv
// Per-sensor category histogram. Each beat on the slave side is either a
// record (tuser 0), which looks up the sensor id in the table, appends it with
// cleared counters if it is new, and bumps the saturating counter of its
// category, or a read-back (tuser 1), which returns the seven counts of one
// table slot as seven master beats with tlast on the final one; a slot with no
// entry returns a single beat with tuser 0 and tlast set. Category 7 allocates
// an entry but counts nothing, and a new id that finds the table full is
// dropped and sets the sticky overflow bit. One item is handled at a time. A
// record searches the table, walking the id memory one entry per cycle, then
// allocates a new entry and clears its counters if the id is new, and then
// does a read-modify-write of the counter. A read-back waits for each result
// beat to be taken before it reads the next. The memories are not cleared
// after reset; only allocated slots are ever read.
module keyed_category_histogram
  import khist_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int NUM_LEVELS    = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: sensor_id[15:0], category[18:16], slot[26:19].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: mode.
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: entry_id[15:0], level[18:16], tally[50:19],
  // entries_used[59:51], table_overflow[60].
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: entry_valid.
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  cmd_t    cmd;
  status_t status;

  khist_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  khist_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NUM_LEVELS    (NUM_LEVELS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .in_data_i         (s_axis_tdata),
    .in_mode_i         (s_axis_tuser),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .out_data_o        (m_axis_tdata),
    .out_entry_valid_o (m_axis_tuser),
    .out_last_o        (m_axis_tlast)
  );

endmodule

FILE: tb/sv/khist_tb_pkg.sv
package khist_tb_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int NUM_LEVELS    = 7;

  localparam logic [2:0] CAT_UNKNOWN = 3'd7;

  typedef enum logic {
    MODE_RECORD = 1'b0,
    MODE_READ   = 1'b1
  } mode_e;

endpackage

FILE: tb/sv/khist_checker.sv
module khist_checker
  import khist_pkg::*;
  import khist_tb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // Fields from bit 0: sensor_id[15:0], category[18:16], slot[26:19].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: mode.
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: entry_id[15:0], level[18:16], tally[50:19],
  // entries_used[59:51], table_overflow[60].
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: entry_valid.
  input  logic                  m_axis_tuser,
  input  logic                  m_axis_tlast,
  output int                    fails_o,
  output int                    pending_o
);

  typedef struct packed {
    logic                   valid;
    logic [SENSOR_ID_W-1:0] id;
    logic [LEVEL_W-1:0]     level;
    logic [TALLY_W-1:0]     tally;
    logic [USED_W-1:0]      used;
    logic                   ovf;
    logic                   last;
  } readback_t;

  logic [SENSOR_ID_W-1:0] mirror_ids [TABLE_ENTRIES];
  logic [TALLY_W-1:0]     mirror_counts [TABLE_ENTRIES][NUM_LEVELS];
  logic [USED_W-1:0]      mirror_used;
  logic                   mirror_ovf;
  readback_t              readback_q [$];

  task automatic count_sample(input logic [SENSOR_ID_W-1:0] id,
                              input logic [CATEGORY_W-1:0] cat);
    int idx;
    idx = -1;
    for (int i = 0; i < int'(mirror_used); i++) begin
      if (idx < 0 && mirror_ids[i] == id) idx = i;
    end
    if (idx < 0) begin
      if (int'(mirror_used) >= TABLE_ENTRIES) begin
        mirror_ovf = 1'b1;
      end else begin
        idx = int'(mirror_used);
        mirror_ids[idx] = id;
        for (int k = 0; k < NUM_LEVELS; k++) mirror_counts[idx][k] = '0;
        mirror_used = mirror_used + USED_W'(1);
      end
    end
    if (idx >= 0 && int'(cat) < NUM_LEVELS && mirror_counts[idx][cat] != '1) begin
      mirror_counts[idx][cat] = mirror_counts[idx][cat] + TALLY_W'(1);
    end
  endtask

  task automatic queue_readback(input logic [SLOT_W-1:0] slot);
    readback_t beat;
    beat = '0;
    beat.used = mirror_used;
    beat.ovf = mirror_ovf;
    if (int'(slot) >= int'(mirror_used)) begin
      beat.last = 1'b1;
      readback_q.push_back(beat);
    end else begin
      for (int k = 0; k < NUM_LEVELS; k++) begin
        beat.valid = 1'b1;
        beat.id = mirror_ids[slot];
        beat.level = LEVEL_W'(k);
        beat.tally = mirror_counts[slot][k];
        beat.last = (k == NUM_LEVELS - 1);
        readback_q.push_back(beat);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fails_o++;
    end
  endtask

  task automatic check_beat();
    readback_t want;
    if (readback_q.size() == 0) begin
      $error("result beat with no read-back outstanding");
      fails_o++;
    end else begin
      want = readback_q.pop_front();
      compare_field("entry_valid", 32'(want.valid), 32'(m_axis_tuser));
      compare_field("entry_id", 32'(want.id),
                    32'(m_axis_tdata[OUT_ID_LSB +: SENSOR_ID_W]));
      compare_field("level", 32'(want.level),
                    32'(m_axis_tdata[OUT_LEVEL_LSB +: LEVEL_W]));
      compare_field("tally", want.tally, m_axis_tdata[OUT_TALLY_LSB +: TALLY_W]);
      compare_field("entries_used", 32'(want.used),
                    32'(m_axis_tdata[OUT_USED_LSB +: USED_W]));
      compare_field("table_overflow", 32'(want.ovf), 32'(m_axis_tdata[OUT_OVF_LSB]));
      compare_field("last", 32'(want.last), 32'(m_axis_tlast));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_used = '0;
      mirror_ovf = 1'b0;
      readback_q.delete();
      fails_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_beat();
      if (s_axis_tvalid && s_axis_tready) begin
        if (mode_e'(s_axis_tuser) == MODE_READ) begin
          queue_readback(s_axis_tdata[IN_SLOT_LSB +: SLOT_W]);
        end else begin
          count_sample(s_axis_tdata[IN_ID_LSB +: SENSOR_ID_W],
                       s_axis_tdata[IN_CAT_LSB +: CATEGORY_W]);
        end
      end
    end
    pending_o = readback_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  import khist_pkg::*;
  import khist_tb_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // Fields from bit 0: sensor_id[15:0], category[18:16], slot[26:19].
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // Fields from bit 0: mode.
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // Fields from bit 0: entry_id[15:0], level[18:16], tally[50:19],
  // entries_used[59:51], table_overflow[60].
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // Fields from bit 0: entry_valid.
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  int fails;
  int pending;
  int src_idle_pct;
  int snk_idle_pct;

  logic [SENSOR_ID_W-1:0] known_ids [$];
  bit                     id_taken [65536];

  keyed_category_histogram #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .NUM_LEVELS   (NUM_LEVELS)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  khist_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fails_o      (fails),
    .pending_o    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_beat(input mode_e mode, input logic [SENSOR_ID_W-1:0] id,
                           input logic [CATEGORY_W-1:0] cat,
                           input logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = mode;
    s_axis_tdata = '0;
    s_axis_tdata[IN_ID_LSB +: SENSOR_ID_W] = id;
    s_axis_tdata[IN_CAT_LSB +: CATEGORY_W] = cat;
    s_axis_tdata[IN_SLOT_LSB +: SLOT_W] = slot;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [SENSOR_ID_W-1:0] fresh_id();
    logic [SENSOR_ID_W-1:0] id;
    id = SENSOR_ID_W'($urandom);
    while (id_taken[id]) id = SENSOR_ID_W'($urandom);
    return id;
  endfunction

  task automatic send_record(input logic [SENSOR_ID_W-1:0] id,
                             input logic [CATEGORY_W-1:0] cat);
    if (!id_taken[id] && known_ids.size() < TABLE_ENTRIES) begin
      id_taken[id] = 1'b1;
      known_ids.push_back(id);
    end
    send_beat(MODE_RECORD, id, cat, SLOT_W'($urandom));
  endtask

  task automatic send_read(input logic [SLOT_W-1:0] slot);
    send_beat(MODE_READ, SENSOR_ID_W'($urandom), CATEGORY_W'($urandom), slot);
  endtask

  task automatic random_item();
    if ($urandom_range(99) < 70) begin
      if (known_ids.size() == 0 || $urandom_range(99) < 75) begin
        send_record(fresh_id(), CATEGORY_W'($urandom));
      end else begin
        send_record(known_ids[$urandom_range(known_ids.size() - 1)],
                    CATEGORY_W'($urandom));
      end
    end else if (known_ids.size() != 0 && $urandom_range(99) < 70) begin
      send_read(SLOT_W'($urandom_range(known_ids.size() - 1)));
    end else begin
      send_read(SLOT_W'($urandom));
    end
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    src_idle_pct = 23;
    snk_idle_pct = 51;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty table, extreme ids and categories, unknown category, partial fill.
    send_read(SLOT_W'(0));
    send_read(SLOT_W'(255));
    send_record(16'h0000, 3'd0);
    send_record(16'hFFFF, 3'd6);
    send_record(16'h0000, 3'd6);
    send_record(16'hFFFF, 3'd0);
    send_record(16'h5A5A, CAT_UNKNOWN);
    send_record(16'h0000, CAT_UNKNOWN);
    for (int c = 1; c <= 5; c++) send_record(16'hA5A5, CATEGORY_W'(c));
    for (int s = 0; s < 4; s++) send_read(SLOT_W'(s));
    send_read(SLOT_W'(4));
    send_read(SLOT_W'(255));

    for (int n = 0; n < 40; n++) random_item();

    src_idle_pct = 51;
    snk_idle_pct = 23;
    for (int n = 0; n < 20; n++) random_item();
    drain();
    for (int n = 0; n < 20; n++) random_item();

    // Fill the table, then push new sensors into a full table.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    while (known_ids.size() < TABLE_ENTRIES) begin
      if ($urandom_range(9) == 0) begin
        send_read(SLOT_W'($urandom_range(known_ids.size() - 1)));
      end else begin
        send_record(fresh_id(), CATEGORY_W'($urandom));
      end
    end
    send_record(fresh_id(), 3'd0);
    send_record(fresh_id(), CAT_UNKNOWN);
    send_read(SLOT_W'(0));
    send_read(SLOT_W'(255));
    for (int n = 0; n < 10; n++) random_item();

    drain();
    repeat (300) @(negedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #15000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
